/* rtl/core/sawc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the set-associative write-back cache model.
// Used by the controller, the datapath, the top level and the checker.
package sawc_pkg;

   // Default geometry
   localparam int DEF_NUM_SETS    = 8;
   localparam int DEF_NUM_WAYS    = 4;
   localparam int DEF_BLOCK_BYTES = 32;

   localparam int ADDR_W  = 32;
   localparam int LAT_W   = 8;
   localparam int STALL_W = 9;
   localparam int CNT_W   = 32;
   localparam int CSR_IDX_W = 2;

   // Operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_STORE = 1'b1;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_CACHE_ENABLE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_LATENCY  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_LATENCY = 2'd2;

   // Register reset values
   localparam logic             RST_CACHE_ENABLE  = 1'b1;
   localparam logic [LAT_W-1:0] RST_READ_LATENCY  = 8'd30;
   localparam logic [LAT_W-1:0] RST_WRITE_LATENCY = 8'd10;

   // Request word
   typedef struct packed {
      logic              operation;
      logic [ADDR_W-1:0] address;
   } req_word_type;

   // Response word
   typedef struct packed {
      logic [STALL_W-1:0] stall_cycles;
      logic               hit;
      logic               did_writeback;
      logic [CNT_W-1:0]   load_total;
      logic [CNT_W-1:0]   store_total;
      logic [CNT_W-1:0]   load_miss_total;
      logic [CNT_W-1:0]   store_miss_total;
      logic [CNT_W-1:0]   writeback_total;
   } rsp_word_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch request and read the set row
      logic lookup;    // compare, update the row, register the response
   } sawc_cmd_type;

endpackage

/* rtl/core/set_assoc_writeback_cache_model_unit.sv */
`timescale 1ns / 1ps
// Top level of the set-associative write-back cache timing model.
// Depends on sawc_pkg, sawc_ctrl and sawc_datapath.
//
//   channel  ports                                     flow control
//   -------  ----------------------------------------  ----------------------
//   request  start, busy, req_word                     taken when start & !busy
//   result   rsp_valid, rsp_word                       one-cycle strobe
//   config   csr_valid, csr_ready, csr_index, csr_data taken when valid & ready
//
// Each access reads the set's tag and state row from memory when its word
// is taken, then compares the ways and writes the row back. The result strobe
// comes in the following cycle, in which the next word can already be taken.
// Reset is synchronous; per-set row valid bits make every set read as empty,
// so there is no clearing pass. The result receiver cannot stall the block.
module set_assoc_writeback_cache_model_unit #(
   parameter int NUM_SETS    = sawc_pkg::DEF_NUM_SETS,
   parameter int NUM_WAYS    = sawc_pkg::DEF_NUM_WAYS,
   parameter int BLOCK_BYTES = sawc_pkg::DEF_BLOCK_BYTES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  sawc_pkg::req_word_type         req_word,
   output logic                           rsp_valid,
   output sawc_pkg::rsp_word_type         rsp_word,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sawc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sawc_pkg::LAT_W-1:0]     csr_data
);
   import sawc_pkg::*;

   sawc_cmd_type cmd;

   // registers take writes at any time
   assign csr_ready = 1'b1;

   sawc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   sawc_datapath #(
      .NUM_SETS    (NUM_SETS),
      .NUM_WAYS    (NUM_WAYS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_word  (req_word),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

/* rtl/core/sawc_ctrl.sv */
`timescale 1ns / 1ps
// Controller for the cache model: two-state sequencer driving the datapath.
// Depends on sawc_pkg.
module sawc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output sawc_pkg::sawc_cmd_type cmd
);
   import sawc_pkg::*;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_LOOKUP = 1'b1;

   logic state_ff;
   logic state_in;

   // next state: a taken word moves to lookup, then back to idle
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (start) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy        = (state_ff == ST_LOOKUP);
   assign cmd.capture = start && (state_ff == ST_IDLE);
   assign cmd.lookup  = (state_ff == ST_LOOKUP);

endmodule

/* rtl/core/sawc_datapath.sv */
`timescale 1ns / 1ps
// Datapath for the cache model: config registers, tag and state memories,
// way compare, counters and the response register. Depends on sawc_pkg.
module sawc_datapath #(
   parameter int NUM_SETS    = sawc_pkg::DEF_NUM_SETS,
   parameter int NUM_WAYS    = sawc_pkg::DEF_NUM_WAYS,
   parameter int BLOCK_BYTES = sawc_pkg::DEF_BLOCK_BYTES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sawc_pkg::sawc_cmd_type              cmd,
   input  sawc_pkg::req_word_type              req_word,
   input  logic                                csr_valid,
   input  logic [sawc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sawc_pkg::LAT_W-1:0]          csr_data,
   output logic                                rsp_valid,
   output sawc_pkg::rsp_word_type              rsp_word
);
   import sawc_pkg::*;

   localparam int OFF_W = $clog2(BLOCK_BYTES);
   localparam int SET_W = $clog2(NUM_SETS);
   localparam int TAG_W = ADDR_W - OFF_W - SET_W;
   localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(NUM_WAYS - 1);

   typedef logic [NUM_WAYS-1:0][TAG_W-1:0] tag_row_type;
   typedef struct packed {
      logic [WAY_W-1:0]    victim;
      logic [NUM_WAYS-1:0] dirty;
      logic [NUM_WAYS-1:0] valid;
   } meta_row_type;

   // Config registers
   logic             cache_enable_ff;
   logic [LAT_W-1:0] read_latency_ff;
   logic [LAT_W-1:0] write_latency_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cache_enable_ff  <= RST_CACHE_ENABLE;
         read_latency_ff  <= RST_READ_LATENCY;
         write_latency_ff <= RST_WRITE_LATENCY;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CACHE_ENABLE:  cache_enable_ff  <= csr_data[0];
            CSR_READ_LATENCY:  read_latency_ff  <= csr_data;
            CSR_WRITE_LATENCY: write_latency_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Captured request and row read data
   logic              op_ff;
   logic [ADDR_W-1:0] addr_ff;
   tag_row_type       tag_rd_ff;
   meta_row_type      meta_rd_ff;

   tag_row_type  tag_mem  [NUM_SETS];
   meta_row_type meta_mem [NUM_SETS];
   logic [NUM_SETS-1:0] row_valid_ff;

   logic [SET_W-1:0] req_set;
   logic [SET_W-1:0] set;
   logic [TAG_W-1:0] tag;
   assign req_set = req_word.address[OFF_W +: SET_W];
   assign set     = addr_ff[OFF_W +: SET_W];
   assign tag     = addr_ff[ADDR_W-1 -: TAG_W];

   // Lookup logic
   logic                row_ok;
   logic [NUM_WAYS-1:0] valid_w;
   logic [NUM_WAYS-1:0] dirty_w;
   logic [WAY_W-1:0]    victim_w;
   logic                hit_found;
   logic [WAY_W-1:0]    hit_way;
   logic                wb_needed;
   tag_row_type         tag_wr;
   meta_row_type        meta_wr;
   logic [STALL_W-1:0]  stall_calc;

   always_comb begin
      row_ok    = row_valid_ff[set];
      valid_w   = row_ok ? meta_rd_ff.valid  : '0;
      dirty_w   = row_ok ? meta_rd_ff.dirty  : '0;
      victim_w  = row_ok ? meta_rd_ff.victim : '0;
      hit_found = 1'b0;
      hit_way   = '0;
      // first matching valid way wins
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (!hit_found && valid_w[w] && (tag_rd_ff[w] == tag)) begin
            hit_found = 1'b1;
            hit_way   = WAY_W'(w);
         end
      end
      wb_needed      = !hit_found && valid_w[victim_w] && dirty_w[victim_w];
      tag_wr         = tag_rd_ff;
      meta_wr.valid  = valid_w;
      meta_wr.dirty  = dirty_w;
      meta_wr.victim = victim_w;
      if (hit_found) begin
         if (op_ff == OP_STORE) meta_wr.dirty[hit_way] = 1'b1;
      end else begin
         tag_wr[victim_w]        = tag;
         meta_wr.valid[victim_w] = 1'b1;
         meta_wr.dirty[victim_w] = (op_ff == OP_STORE);
         meta_wr.victim          = (victim_w == LAST_WAY) ? '0 : victim_w + 1'b1;
      end
      // stall count
      if (!cache_enable_ff) begin
         stall_calc = {1'b0, (op_ff == OP_STORE) ? write_latency_ff : read_latency_ff};
      end else if (hit_found) begin
         stall_calc = '0;
      end else begin
         stall_calc = {1'b0, read_latency_ff}
                    + (wb_needed ? {1'b0, write_latency_ff} : '0);
      end
   end

   logic mem_we;
   assign mem_we = cmd.lookup && cache_enable_ff;

   // Memories: one row per set, read at capture, written at lookup while the cache is enabled
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[set]  <= tag_wr;
         meta_mem[set] <= meta_wr;
      end
      if (cmd.capture) begin
         op_ff      <= req_word.operation;
         addr_ff    <= req_word.address;
         tag_rd_ff  <= tag_mem[req_set];
         meta_rd_ff <= meta_mem[req_set];
      end
   end

   // Per-set row valid bits stand in for a clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (mem_we) begin
         row_valid_ff[set] <= 1'b1;
      end
   end

   // Counters
   logic [CNT_W-1:0] load_cnt_ff, store_cnt_ff, load_miss_ff, store_miss_ff, wb_cnt_ff;
   logic [CNT_W-1:0] load_cnt_in, store_cnt_in, load_miss_in, store_miss_in, wb_cnt_in;

   always_comb begin
      load_cnt_in   = load_cnt_ff;
      store_cnt_in  = store_cnt_ff;
      load_miss_in  = load_miss_ff;
      store_miss_in = store_miss_ff;
      wb_cnt_in     = wb_cnt_ff;
      if (mem_we) begin
         if (op_ff == OP_STORE) begin
            store_cnt_in = store_cnt_ff + 32'd1;
            if (!hit_found) store_miss_in = store_miss_ff + 32'd1;
         end else begin
            load_cnt_in = load_cnt_ff + 32'd1;
            if (!hit_found) load_miss_in = load_miss_ff + 32'd1;
         end
         if (wb_needed) wb_cnt_in = wb_cnt_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff   <= '0;
         store_cnt_ff  <= '0;
         load_miss_ff  <= '0;
         store_miss_ff <= '0;
         wb_cnt_ff     <= '0;
      end else begin
         load_cnt_ff   <= load_cnt_in;
         store_cnt_ff  <= store_cnt_in;
         load_miss_ff  <= load_miss_in;
         store_miss_ff <= store_miss_in;
         wb_cnt_ff     <= wb_cnt_in;
      end
   end

   // Response register
   logic         rsp_valid_ff;
   rsp_word_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.lookup;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         rsp_ff.stall_cycles     <= stall_calc;
         rsp_ff.hit              <= cache_enable_ff && hit_found;
         rsp_ff.did_writeback    <= cache_enable_ff && wb_needed;
         rsp_ff.load_total       <= load_cnt_in;
         rsp_ff.store_total      <= store_cnt_in;
         rsp_ff.load_miss_total  <= load_miss_in;
         rsp_ff.store_miss_total <= store_miss_in;
         rsp_ff.writeback_total  <= wb_cnt_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

/* rtl/core/sawc_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the cache model top level, with its bind statement.
// Depends on sawc_pkg and set_assoc_writeback_cache_model_unit.
module sawc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input sawc_pkg::rsp_word_type rsp_word
);
   import sawc_pkg::*;

   // a taken word yields its result strobe after its lookup state
   a_rsp_timing: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("result strobe missing after accepted word");

   // busy lasts exactly one cycle per word
   a_busy_once: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held longer than one cycle");

   // a strobe only follows a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a lookup");

   // a hit costs nothing and never writes back
   a_hit_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.hit) |-> (rsp_word.stall_cycles == '0 && !rsp_word.did_writeback))
      else $error("hit reported with stalls or writeback");

endmodule

bind set_assoc_writeback_cache_model_unit sawc_checker u_sawc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);
